// ===== rtl/sap_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sap_pkg: shared types and constants
// Payload structs, controller/datapath command and status groups, sizes.
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int SPECTRUM_BINS = 32768;
    localparam int LINE_PIXELS   = 2048;
    localparam int BIN_W         = $clog2(SPECTRUM_BINS);
    localparam int PIX_W         = $clog2(LINE_PIXELS + 1);
    localparam int SUM_W         = 32;
    localparam int DIV_CNT_W     = $clog2(SUM_W);

    localparam logic [1:0] CFG_AVG_COUNT      = 2'd0;
    localparam logic [1:0] CFG_BINS_PER_PIXEL = 2'd1;
    localparam logic [1:0] CFG_START_BIN      = 2'd2;

    typedef struct packed {
        logic [23:0] bin_power;
        logic        strong_mark;
        logic        blank_frame;
        logic        last_bin;
    } t_in;

    typedef struct packed {
        logic [23:0] pixel_level;
        logic        strong_res;
        logic        blanked;
        logic        last_pixel;
    } t_out;

    typedef struct packed {
        logic [7:0]  avg_count;
        logic [6:0]  bins_per_pixel;
        logic [14:0] start_bin;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic rmw;
        logic div_step;
        logic pool;
        logic emit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic take;
        logic div_done;
        logic close;
        logic out_free;
    } t_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_POOL,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/sap_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sap_ctrl: sequencing controller
// Steps one bin through read and accumulate; a taken bin goes on to divide and pool, a closing bin to emit.
// ----------------------------------------------------------------------------
module sap_ctrl import sap_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rmw = 1'b1;
                if (i_sts.take) begin
                    n_state = S_DIV;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_POOL;
            end
            S_POOL: begin
                o_cmd.pool = 1'b1;
                if (i_sts.close) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/sap_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sap_dp: accumulate, divide and pool datapath
// Per-bin sum memory, bit-serial divider, running maximum, line counters.
// ----------------------------------------------------------------------------
module sap_dp import sap_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in,
    input  wire t_cfg i_cfg,
    input  wire t_cmd i_cmd,
    input  wire logic i_out_free,
    output t_sts      o_sts,
    output t_out      o_pix
);

    logic [SUM_W-1:0]     mem [SPECTRUM_BINS];
    logic [SUM_W-1:0]     r_rd;
    t_in                  r_in;
    logic [BIN_W-1:0]     r_bin;
    logic [7:0]           r_cnt;
    logic [PIX_W-1:0]     r_pix;
    logic [5:0]           r_pool;
    logic [SUM_W-1:0]     r_max;
    logic [SUM_W-1:0]     r_q;
    logic [9:0]           r_rem;
    logic [8:0]           r_dvs;
    logic [DIV_CNT_W-1:0] r_dcnt;

    logic [SUM_W-1:0] sum;
    logic [7:0]       avg_eff;
    logic [6:0]       nbpp;
    logic [8:0]       n_div;
    logic             final_spec, end_spec, lastpix;
    logic [9:0]       rem_sh;
    logic [BIN_W:0]   bin_ext;

    always_comb begin
        avg_eff    = (i_cfg.avg_count == 8'd0) ? 8'd1 : i_cfg.avg_count;
        nbpp       = (i_cfg.bins_per_pixel == 7'd0) ? 7'd1 :
                     ((i_cfg.bins_per_pixel > 7'd64) ? 7'd64 : i_cfg.bins_per_pixel);
        n_div      = {1'b0, r_cnt} + 9'd1;
        final_spec = n_div >= {1'b0, avg_eff};
        end_spec   = r_in.last_bin || (r_bin == BIN_W'(SPECTRUM_BINS - 1));
        sum        = (r_cnt == 8'd0) ? SUM_W'(r_in.bin_power)
                                     : r_rd + SUM_W'(r_in.bin_power);
        rem_sh     = {r_rem[8:0], r_q[SUM_W-1]};
        bin_ext    = {1'b0, r_bin} + (BIN_W + 1)'(nbpp);
        lastpix    = (r_pix == PIX_W'(LINE_PIXELS - 1))
                     || (bin_ext >= (BIN_W + 1)'(SPECTRUM_BINS));

        o_sts.take     = final_spec
                         && (32'(r_bin) > 32'(i_cfg.start_bin))
                         && (r_pix < PIX_W'(LINE_PIXELS));
        o_sts.div_done = r_dcnt == DIV_CNT_W'(SUM_W - 1);
        o_sts.close    = ({1'b0, r_pool} + 7'd1) >= nbpp;
        o_sts.out_free = i_out_free;

        o_pix.pixel_level = r_in.blank_frame ? 24'd0 : r_max[23:0];
        o_pix.strong_res  = r_in.blank_frame ? 1'b0 : r_in.strong_mark;
        o_pix.blanked     = r_in.blank_frame;
        o_pix.last_pixel  = lastpix;
    end

    // sum memory: read on accept, write back in the following READ state
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_rd <= mem[r_bin];
        if (i_cmd.rmw) mem[r_bin] <= sum;
    end

    // input hold and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_in <= i_in;
        if (i_cmd.rmw) begin
            r_q    <= sum;
            r_rem  <= '0;
            r_dvs  <= n_div;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + DIV_CNT_W'(1);
            if (rem_sh >= {1'b0, r_dvs}) begin
                r_rem <= rem_sh - {1'b0, r_dvs};
                r_q   <= {r_q[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[SUM_W-2:0], 1'b0};
            end
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin  <= '0;
            r_cnt  <= '0;
            r_pix  <= '0;
            r_pool <= '0;
            r_max  <= '0;
        end else begin
            if (i_cmd.pool) begin
                if (r_q > r_max) r_max <= r_q;
                if (!o_sts.close) r_pool <= r_pool + 6'd1;
            end
            if (i_cmd.emit) begin
                r_pix  <= r_pix + PIX_W'(1);
                r_pool <= '0;
                r_max  <= '0;
            end
            if (i_cmd.finish) begin
                if (end_spec) begin
                    r_bin  <= '0;
                    r_pix  <= '0;
                    r_pool <= '0;
                    r_max  <= '0;
                    r_cnt  <= final_spec ? 8'd0 : n_div[7:0];
                end else begin
                    r_bin <= r_bin + BIN_W'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/spectrum_average_max_pool.sv =====
`default_nettype none
// Output: the bin that closes a pixel passes read, divide, pool and emit, and
//   the pixel is then registered; other bins produce no output.
// Input: a new bin is taken only once the last is done; a pooled bin waits
//   on the 32-step divider, a closing bin also on output stall.
// Reset: synchronous active low; counters and state clear, sum memory has no
//   reset (the first spectrum of each block overwrites it).
// ----------------------------------------------------------------------------
// spectrum_average_max_pool: spectrum averaging with peak decimation
// Accumulates bins over avg_count spectra, averages them on the final
// spectrum and max-pools groups of bins into display pixels.
// ----------------------------------------------------------------------------
module spectrum_average_max_pool import sap_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in        i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out            o_out,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    t_out pix;
    logic r_out_valid;
    t_out r_out;
    logic out_free;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.avg_count      <= 8'd10;
            r_cfg.bins_per_pixel <= 7'd20;
            r_cfg.start_bin      <= 15'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AVG_COUNT:      r_cfg.avg_count      <= i_cfg_data[7:0];
                CFG_BINS_PER_PIXEL: r_cfg.bins_per_pixel <= i_cfg_data[6:0];
                CFG_START_BIN:      r_cfg.start_bin      <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    sap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sap_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .i_out_free (out_free),
        .o_sts      (sts),
        .o_pix      (pix)
    );

    // output register: the pixel waits here while the next bin is taken
    assign out_free = !r_out_valid || i_out_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (cmd.emit) r_out <= pix;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> out_free) else $error("pixel loaded over a pending transfer");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready) else $error("ready while busy");
    a_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.blanked) |-> (o_out.pixel_level == 24'd0 && !o_out.strong_res))
        else $error("blanked pixel carries data");
`endif

endmodule
`default_nettype wire
